// ===== rtl/encoder_speed_position_meter_assert.svh =====
// Assertion macros shared by the encoder meter modules.
`ifndef ENCODER_SPEED_POSITION_METER_ASSERT_SVH
`define ENCODER_SPEED_POSITION_METER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define ESPM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication with the consequent in the next cycle.
`define ESPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/espm_pkg.sv =====
// Package with types and constants of the encoder speed and position meter.
package espm_pkg;
  localparam int CounterBitsDefault = 16;
  localparam logic [15:0] CprReset = 16'd1000;
  localparam logic [15:0] SpmReset = 16'd10;
  localparam logic [19:0] FsReset = 20'd3000;
  localparam logic [15:0] PwmReset = 16'd1000;
  localparam int CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] RegCpr = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegSpm = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegFs = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegPwm = 2'd3;
  localparam int OutBytes = 18;

  // Command passed from the front part to the back part.
  typedef struct packed {
    logic        clear;
    logic        sample;
    logic [31:0] delta;
  } espm_cmd_t;
endpackage

// ===== rtl/espm_front.sv =====
// Front part: tick phase, sample decision and wrap-safe count difference.
module espm_front #(
  parameter int CounterBits = espm_pkg::CounterBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic [CounterBits-1:0] encoder_count,
  input  logic [15:0]           sample_period_ms,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output espm_pkg::espm_cmd_t   cmd
);
  import espm_pkg::*;
  `include "encoder_speed_position_meter_assert.svh"

  logic [15:0] tick_phase;
  logic [15:0] phase_inc;
  logic [CounterBits-1:0] previous_count;
  logic [CounterBits-1:0] diff;
  logic take;

  assign in_ready = !cmd_valid || cmd_ready;
  assign phase_inc = tick_phase + 16'd1;
  assign take = (phase_inc >= sample_period_ms);
  assign diff = encoder_count - previous_count;

  // One-entry queue register toward the back part.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_phase <= '0;
      previous_count <= '0;
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_ready) cmd_valid <= 1'b0;
      if (in_valid && in_ready) begin
        cmd_valid <= 1'b1;
        cmd.clear <= operation;
        cmd.sample <= !operation && take;
        cmd.delta <= 32'(signed'(diff));
        if (operation) begin
          previous_count <= '0;
        end else if (take) begin
          tick_phase <= '0;
          previous_count <= encoder_count;
        end else begin
          tick_phase <= phase_inc;
        end
      end
    end
  end

  `ESPM_ASSERT_NEXT(a_hold, clk, rst, cmd_valid && !cmd_ready, cmd_valid, "command lost")
  `ESPM_ASSERT_IMP(a_excl, clk, rst, cmd_valid, !(cmd.clear && cmd.sample), "clear and sample")
  `ESPM_ASSERT_NEXT(a_load, clk, rst, in_valid && in_ready, cmd_valid, "command not queued")
endmodule

// ===== rtl/espm_divider.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
module espm_divider #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient
);
  localparam int CntBits = $clog2(W + 1);
  logic [CntBits-1:0] count;
  logic [W-1:0] rem;
  logic [W-1:0] dvs;
  logic [W:0] trial;

  assign trial = {rem, quotient[W-1]} - {1'b0, dvs};

  // Shift-subtract loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= CntBits'(W);
      rem <= '0;
      quotient <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (trial[W]) begin
        rem <= {rem[W-2:0], quotient[W-1]};
        quotient <= {quotient[W-2:0], 1'b0};
      end else begin
        rem <= trial[W-1:0];
        quotient <= {quotient[W-2:0], 1'b1};
      end
      count <= count - 1'b1;
      if (count == CntBits'(1)) busy <= 1'b0;
    end
  end
endmodule

// ===== rtl/espm_back.sv =====
// Back part: position, sample count, rpm, duty and compare sequencing.
module espm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  espm_pkg::espm_cmd_t cmd,
  input  logic [15:0]         counts_per_rev,
  input  logic [15:0]         sample_period_ms,
  input  logic [19:0]         full_scale_rpm,
  input  logic [15:0]         pwm_period,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [8*espm_pkg::OutBytes-1:0] out_data
);
  import espm_pkg::*;
  `include "encoder_speed_position_meter_assert.svh"

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_DEN = 6'b000010, S_RPM = 6'b000100,
    S_DUTY = 6'b001000, S_CMP = 6'b010000, S_OUT = 6'b100000
  } state_t;

  state_t state;
  logic [31:0] position_total, delta_held, rpm_held, samples_total;
  logic [10:0] duty_held;
  logic [15:0] compare_held;
  logic sampled, neg;
  logic [31:0] mag, den;
  logic [47:0] div_a, div_b, q;
  logic div_start, div_busy, waiting;
  logic [31:0] rmag;
  logic [52:0] cmp_prod;

  espm_divider #(.W(48)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quotient(q)
  );

  assign cmd_ready = (state == S_IDLE) && (!out_valid || out_ready);

  // Divide the rounded compare numerator (below 2^26) by 1000 with a reciprocal
  // multiply: ceil(2^36 / 1000) gives the exact quotient over that range.
  assign cmp_prod = div_a[25:0] * 27'd68719477;

  // Sequencer over the two divisions and the compare scaling.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      waiting <= 1'b0;
      position_total <= '0; delta_held <= '0; rpm_held <= '0;
      samples_total <= '0; duty_held <= '0; compare_held <= '0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            sampled <= cmd.sample;
            if (cmd.clear) begin
              position_total <= '0; delta_held <= '0; rpm_held <= '0;
              samples_total <= '0;
              state <= S_OUT;
            end else if (cmd.sample) begin
              delta_held <= cmd.delta;
              position_total <= position_total + cmd.delta;
              samples_total <= samples_total + 32'd1;
              neg <= cmd.delta[31];
              mag <= cmd.delta[31] ? 32'd0 - cmd.delta : cmd.delta;
              den <= counts_per_rev * sample_period_ms;
              state <= S_DEN;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_DEN: begin
          if (den == 32'd0) begin
            rmag <= '0;
            state <= S_DUTY;
          end else begin
            div_a <= 48'(mag) * 48'd60000;
            div_b <= 48'(den);
            div_start <= 1'b1;
            waiting <= 1'b1;
            state <= S_RPM;
          end
        end
        S_RPM: begin
          if (waiting && !div_start && !div_busy) begin
            waiting <= 1'b0;
            if (q > 48'h80000000) rmag <= 32'h80000000;
            else if (!neg && q > 48'h7fffffff) rmag <= 32'h7fffffff;
            else rmag <= q[31:0];
            state <= S_DUTY;
          end
        end
        S_DUTY: begin
          rpm_held <= neg ? 32'd0 - rmag : rmag;
          if (full_scale_rpm == 20'd0) begin
            duty_held <= (rmag != 0) ? 11'd1000 : 11'd0;
            state <= S_CMP;
          end else if (!waiting) begin
            div_a <= 48'(rmag) * 48'd1000;
            div_b <= 48'(full_scale_rpm);
            div_start <= 1'b1;
            waiting <= 1'b1;
          end else if (!div_start && !div_busy) begin
            waiting <= 1'b0;
            duty_held <= (q > 48'd1000) ? 11'd1000 : q[10:0];
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (!waiting) begin
            div_a <= 48'(duty_held) * 48'(pwm_period) + 48'd500;
            waiting <= 1'b1;
          end else begin
            waiting <= 1'b0;
            compare_held <= cmp_prod[51:36];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_data <= {5'd0, compare_held, duty_held[9:0], samples_total,
                       rpm_held, delta_held[15:0], position_total, sampled};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ESPM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `ESPM_ASSERT_IMP(a_onehot, clk, rst, 1'b1, $onehot(state), "state not one-hot")
  `ESPM_ASSERT_IMP(a_duty, clk, rst, 1'b1, duty_held <= 11'd1000, "duty out of range")
endmodule

// ===== rtl/encoder_speed_position_meter.sv =====
// A tick without a sample passes the front queue register, then the back part's S_IDLE and S_OUT.
// A sampling tick runs two 48-step divisions in one shared divider (each skipped when its
// divisor is zero), then a reciprocal multiply for the compare value.
// Throughput: one item in flight in the back part; the front queue holds one more.
// Reset (rst, synchronous, active high) clears control and measurement state and loads register defaults.
// Top level of the encoder speed and position meter.
module encoder_speed_position_meter #(
  parameter int COUNTER_BITS = espm_pkg::CounterBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [COUNTER_BITS-1:0] s_axis_tdata,  // encoder_count
  input  logic        s_axis_tuser,             // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sample_taken, position, last_delta, speed_rpm, sample_count, duty_permille, pwm_compare
  output logic [8*espm_pkg::OutBytes-1:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [espm_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [19:0] cfg_data
);
  import espm_pkg::*;

  logic [15:0] counts_per_rev, sample_period_ms, pwm_period;
  logic [19:0] full_scale_rpm;
  logic cmd_valid, cmd_ready;
  espm_cmd_t cmd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev <= CprReset;
      sample_period_ms <= SpmReset;
      full_scale_rpm <= FsReset;
      pwm_period <= PwmReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegCpr: counts_per_rev <= cfg_data[15:0];
        RegSpm: sample_period_ms <= cfg_data[15:0];
        RegFs: full_scale_rpm <= cfg_data;
        RegPwm: pwm_period <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  espm_front #(.CounterBits(COUNTER_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .operation(s_axis_tuser), .encoder_count(s_axis_tdata),
    .sample_period_ms(sample_period_ms),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  espm_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .counts_per_rev(counts_per_rev), .sample_period_ms(sample_period_ms),
    .full_scale_rpm(full_scale_rpm), .pwm_period(pwm_period),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );
endmodule

// ===== tb/sv/tb_encoder_speed_position_meter.sv =====
// Self-checking testbench for the encoder speed and position meter.
module tb_encoder_speed_position_meter;
  timeunit 1ns;
  timeprecision 1ps;

  import espm_pkg::*;

  localparam bit OpTick  = 1'b0;
  localparam bit OpClear = 1'b1;
  localparam int DrainCycles = 400;

  typedef struct packed {
    logic [15:0] pwm_compare;
    logic [9:0]  duty_permille;
    logic [31:0] sample_count;
    logic [31:0] speed_rpm;
    logic [15:0] last_delta;
    logic [31:0] position;
    logic        sample_taken;
  } meter_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // encoder_count
  logic        s_axis_tuser = 1'b0;  // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // sample_taken, position, last_delta, speed_rpm, sample_count, duty_permille, pwm_compare
  logic [8*OutBytes-1:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;

  // Predictor copy of the registers and measurement state.
  logic [15:0] cpr_reg, spm_reg, pwm_reg;
  logic [19:0] fs_reg;
  logic [15:0] phase_q, prev_count_q, delta_q;
  logic [31:0] position_q, rpm_q, samples_q;
  logic [9:0]  duty_q;
  logic [15:0] compare_q;

  meter_result_t pending_results[$];
  int errors = 0;
  int beats_in = 0, beats_out = 0, samples_seen = 0, clears_sent = 0;
  bit quiet = 1'b0;
  int ready_hold = 0;
  logic [15:0] last_count = '0;

  encoder_speed_position_meter dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the predicted meter state by one input beat.
  function automatic meter_result_t meter_predict(bit op, logic [15:0] count);
    meter_result_t r;
    logic [15:0] diff;
    logic [63:0] mag, den, q, d;
    bit neg;
    r = '0;
    if (op == OpClear) begin
      prev_count_q = '0;
      position_q = '0;
      delta_q = '0;
      rpm_q = '0;
      samples_q = '0;
    end else begin
      phase_q = phase_q + 16'd1;
      if (phase_q >= spm_reg) begin
        phase_q = '0;
        r.sample_taken = 1'b1;
        diff = count - prev_count_q;
        prev_count_q = count;
        delta_q = diff;
        position_q = position_q + {{16{diff[15]}}, diff};
        samples_q = samples_q + 32'd1;
        neg = diff[15];
        mag = neg ? 64'(-$signed({1'b1, diff})) : 64'(diff);
        den = 64'(cpr_reg) * 64'(spm_reg);
        q = (den == 0) ? 64'd0 : (mag * 64'd60000) / den;
        rpm_q = neg ? 32'(-q) : 32'(q);
        if (fs_reg == 0) d = (q != 0) ? 64'd1000 : 64'd0;
        else d = (q * 64'd1000) / 64'(fs_reg);
        duty_q = (d > 1000) ? 10'd1000 : 10'(d);
        compare_q = 16'((64'(duty_q) * 64'(pwm_reg) + 64'd500) / 64'd1000);
      end
    end
    r.position = position_q;
    r.last_delta = delta_q;
    r.speed_rpm = rpm_q;
    r.sample_count = samples_q;
    r.duty_permille = duty_q;
    r.pwm_compare = compare_q;
    return r;
  endfunction

  // Receiver stalls in random bursts.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare each output beat with the oldest expected result.
  always @(posedge clk) begin
    meter_result_t exp_r, act_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      act_r = m_axis_tdata[$bits(meter_result_t)-1:0];
      beats_out++;
      if (pending_results.size() == 0) begin
        $error("output beat with no expected result");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.sample_taken) samples_seen++;
        check_field("sample_taken", exp_r.sample_taken, act_r.sample_taken);
        check_field("position", exp_r.position, act_r.position);
        check_field("last_delta", exp_r.last_delta, act_r.last_delta);
        check_field("speed_rpm", exp_r.speed_rpm, act_r.speed_rpm);
        check_field("sample_count", exp_r.sample_count, act_r.sample_count);
        check_field("duty_permille", exp_r.duty_permille, act_r.duty_permille);
        check_field("pwm_compare", exp_r.pwm_compare, act_r.pwm_compare);
      end
    end
  end

  // Send one beat and record its expected result once accepted.
  task automatic send_item(bit op, logic [15:0] count);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= count;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(meter_predict(op, count));
    beats_in++;
    if (op == OpClear) begin
      clears_sent++;
      last_count = '0;
    end else begin
      last_count = count;
    end
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register write, only issued once the block has gone idle.
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [19:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegCpr: cpr_reg = value[15:0];
      RegSpm: spm_reg = value[15:0];
      RegFs:  fs_reg = value;
      RegPwm: pwm_reg = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] cpr, logic [15:0] spm, logic [19:0] fs,
                            logic [15:0] pwm);
    wait_drained();
    write_reg(RegCpr, 20'(cpr));
    write_reg(RegSpm, 20'(spm));
    write_reg(RegFs, fs);
    write_reg(RegPwm, 20'(pwm));
  endtask

  // Defaults, clear command, counter extremes and wrap in both directions.
  task automatic test_directed_extremes();
    repeat (12) send_item(OpTick, 16'd150);
    send_item(OpClear, 16'hFFFF);
    set_config(16'd1, 16'd1, 20'd1, 16'd65535);
    send_item(OpTick, 16'h7FFF);
    send_item(OpTick, 16'hFFFF);
    send_item(OpTick, 16'h0000);
    send_item(OpTick, 16'h8000);
    send_item(OpTick, 16'h0000);
    send_item(OpTick, 16'h0001);
    set_config(16'd65535, 16'd1, 20'd1000000, 16'd1);
    send_item(OpTick, 16'h8001);
    send_item(OpTick, 16'h0002);
    send_item(OpClear, 16'h1234);
    send_item(OpTick, 16'h0010);
  endtask

  // Period lowered below the current phase forces a sample on the next tick.
  task automatic test_phase_above_period();
    set_config(16'd1000, 16'd65535, 20'd3000, 16'd1000);
    repeat (6) send_item(OpTick, 16'd500);
    set_config(16'd1000, 16'd2, 20'd3000, 16'd1000);
    send_item(OpTick, 16'd900);
    send_item(OpTick, 16'd950);
    send_item(OpTick, 16'd1000);
  endtask

  // Random phase: mostly steady motion, some jumps and clears.
  task automatic test_random_motion(int n, bit pause_once);
    int k;
    logic [15:0] c;
    for (k = 0; k < n; k++) begin
      if (pause_once && k == n / 2) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 19))
        0: send_item(OpClear, 16'($urandom));
        1, 2: send_item(OpTick, 16'($urandom));
        default: begin
          c = last_count + 16'($signed($urandom_range(0, 400)) - 200);
          send_item(OpTick, c);
        end
      endcase
    end
  endtask

  initial begin
    cpr_reg = CprReset; spm_reg = SpmReset; fs_reg = FsReset; pwm_reg = PwmReset;
    phase_q = '0; prev_count_q = '0; delta_q = '0; position_q = '0;
    rpm_q = '0; samples_q = '0; duty_q = '0; compare_q = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_phase_above_period();
    set_config(16'd1000, 16'd1, 20'd3000, 16'd1000);
    test_random_motion(250, 1'b1);
    set_config(16'd4, 16'd3, 20'd50, 16'd65535);
    test_random_motion(250, 1'b0);
    set_config(16'($urandom_range(1, 65535)), 16'd2, 20'($urandom_range(1, 1000000)),
               16'($urandom_range(1, 65535)));
    test_random_motion(250, 1'b0);
    set_config(16'd1, 16'd1, 20'd1000000, 16'd1);
    test_random_motion(250, 1'b0);
    set_config(16'd65535, 16'd4, 20'd1, 16'd333);
    test_random_motion(250, 1'b0);
    set_config(16'd2048, 16'd1, 20'd6000, 16'd20000);
    quiet = 1'b1;
    test_random_motion(350, 1'b0);
    wait_drained();
    $display("Covered %0d input beats (%0d clears), %0d output beats, %0d samples,",
             beats_in, clears_sent, beats_out, samples_seen);
    $display("across several register settings including the range extremes.");
    if (errors == 0) begin
      $display("tb_encoder_speed_position_meter: PASS");
    end else begin
      $display("tb_encoder_speed_position_meter: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #30ms;
    $display("tb_encoder_speed_position_meter: FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/espm_pkg.sv
rtl/espm_front.sv
rtl/espm_divider.sv
rtl/espm_back.sv
rtl/encoder_speed_position_meter.sv
tb/sv/tb_encoder_speed_position_meter.sv
